@@ rtl/bcrd_pkg.sv @@
// ============================================================================
// bcrd_pkg - shared types and constants for the breath cycle rate detector
// Config register map, register reset values and the divider sizing.
// ============================================================================
package bcrd_pkg;

    // APB side
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MIN_AMP   = 3'd0;
    localparam logic [2:0] REG_MAX_AMP   = 3'd1;
    localparam logic [2:0] REG_FS        = 3'd2;
    localparam logic [2:0] REG_LOW_RATE  = 3'd3;
    localparam logic [2:0] REG_HIGH_RATE = 3'd4;
    localparam logic [2:0] REG_RUN_LIMIT = 3'd5;

    // Register reset values
    localparam logic [14:0] RST_MIN_AMP   = 15'd410;
    localparam logic [14:0] RST_MAX_AMP   = 15'd16384;
    localparam logic [15:0] RST_FS        = 16'd3200;
    localparam logic [15:0] RST_LOW_RATE  = 16'd512;
    localparam logic [15:0] RST_HIGH_RATE = 16'd12800;
    localparam logic [3:0]  RST_RUN_LIMIT = 4'd3;

    // Sample counter width default
    localparam int DEF_COUNT_BITS = 16;

    // 60 * 65535 < 2^22
    localparam int DVD_W = 22;

    typedef struct packed {
        logic [14:0] min_amplitude;
        logic [14:0] max_amplitude;
        logic [15:0] sample_rate;
        logic [15:0] lowest_rate;
        logic [15:0] highest_rate;
        logic [3:0]  abnormal_run_limit;
    } cfg_t;

    // 60*x = 64*x - 4*x
    function automatic logic [DVD_W-1:0] times_sixty(input logic [15:0] x);
        return {x, 6'b0} - {4'b0, x, 2'b0};
    endfunction

endpackage

@@ rtl/breath_cycle_rate_detector.sv @@
// ============================================================================
// breath_cycle_rate_detector - breathing rate from threshold crossings
// Hysteresis phase tracker, breath timing and a bit-serial rate divider.
// ============================================================================
//
//  port group   dir  beat contents
//  s_*          in   one sample with upper/lower thresholds and valid flags
//  m_*          out  one status beat per sample (rate, phase, polarity)
//  p*           cfg  APB register access, six settings registers
//
//  A sample is taken in the idle state. A sample that ends a normal breath
//  also runs the rate divide 60*fs/count, one quotient bit per cycle, and
//  then judges the quotient; other samples go straight to the output state.
//  The next sample is taken while the result beat still waits on m_tready;
//  a new result waits in the output state until the output register is free.
//  Reset is synchronous, active low.
//
module breath_cycle_rate_detector #(
    parameter int COUNT_BITS = bcrd_pkg::DEF_COUNT_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] signal, [16] signal_valid, [32:17] upper_level,
    // [33] upper_valid, [49:34] lower_level, [50] lower_valid, [55:51] zero
    input  logic [55:0]                      s_tdata,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] rate, [16] rate_valid, [17] breath_done, [20:18] phase,
    // [21] inspiration_above, [23:22] zero
    output logic [23:0]                      m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bcrd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bcrd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bcrd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam int DW = bcrd_pkg::DVD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_UNKNOWN = 3'd0,
        PH_LOW     = 3'd1,
        PH_HIGH    = 3'd2,
        PH_RISING  = 3'd3,
        PH_FALLING = 3'd4,
        PH_MIDUNK  = 3'd5
    } phase_t;

    bcrd_pkg::cfg_t cfg;

    // ---- configuration ----
    bcrd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---- state ----
    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] first_reg, first_next;
    logic [3:0]            abn_reg, abn_next;
    logic                  pol_reg, pol_next;
    logic                  bvalid_reg, bvalid_next;
    logic [15:0]           rate_reg, rate_next;
    logic                  rate_ok_reg, rate_ok_next;
    logic                  done_reg, done_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [23:0]           m_tdata_reg, m_tdata_next;

    // ---- sample fields ----
    logic signed [15:0]    smp, up, lo;
    logic                  all_valid;
    logic signed [16:0]    spread, min2, max2;
    logic                  spread_bad;
    logic [COUNT_BITS-1:0] cnt_inc;
    phase_t                ph;
    logic                  finish;
    logic                  long_first;
    logic [3:0]            abn_inc, abn_new;
    logic                  flip;

    // ---- divider ----
    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_quot;
    logic                  in_range;

    assign smp       = s_tdata[15:0];
    assign up        = s_tdata[32:17];
    assign lo        = s_tdata[49:34];
    assign all_valid = s_tdata[16] && s_tdata[33] && s_tdata[50];

    // exact 17-bit spread against twice the amplitude limits
    assign spread     = {up[15], up} - {lo[15], lo};
    assign min2       = {1'b0, cfg.min_amplitude, 1'b0};
    assign max2       = {1'b0, cfg.max_amplitude, 1'b0};
    assign spread_bad = (spread < min2) || (spread > max2);

    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // first part longer than second: 2*first > count
    assign long_first = {first_reg, 1'b0} > {1'b0, cnt_inc};
    assign abn_inc    = (abn_reg == 4'hF) ? abn_reg : abn_reg + 4'd1;
    assign abn_new    = long_first ? abn_inc : 4'd0;
    assign flip       = abn_new >= cfg.abnormal_run_limit;

    assign in_range = (div_quot >= {{(DW-16){1'b0}}, cfg.lowest_rate}) &&
                      (div_quot <= {{(DW-16){1'b0}}, cfg.highest_rate});

    bcrd_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (bcrd_pkg::times_sixty(cfg.sample_rate)),
        .divisor  (cnt_inc),
        .done     (div_done),
        .quotient (div_quot)
    );

    // phase entering the crossing checks, after classifying an unknown start
    always_comb begin
        ph = phase_reg;
        if (phase_reg == PH_UNKNOWN) begin
            if (smp < lo)      ph = PH_LOW;
            else if (smp > up) ph = PH_HIGH;
            else               ph = PH_MIDUNK;
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        first_next    = first_reg;
        abn_next      = abn_reg;
        pol_next      = pol_reg;
        bvalid_next   = bvalid_reg;
        rate_next     = rate_reg;
        rate_ok_next  = rate_ok_reg;
        done_next     = done_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        finish        = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cnt_next   = cnt_inc;
                    done_next  = 1'b0;
                    state_next = ST_OUT;
                    if (!all_valid) begin
                        rate_next    = '0;
                        rate_ok_next = 1'b0;
                        bvalid_next  = 1'b0;
                    end else if (spread_bad) begin
                        phase_next   = PH_UNKNOWN;
                        rate_next    = '0;
                        rate_ok_next = 1'b0;
                        bvalid_next  = 1'b0;
                    end else begin
                        phase_next = ph;
                        if (ph == PH_LOW && smp > lo) begin
                            phase_next = PH_RISING;
                        end else if (ph == PH_HIGH && smp < up) begin
                            phase_next = PH_FALLING;
                        end else if ((ph == PH_RISING || ph == PH_MIDUNK) && smp > up) begin
                            phase_next = PH_HIGH;
                            if (pol_reg) finish = 1'b1;
                            else         first_next = cnt_inc;
                        end else if ((ph == PH_FALLING || ph == PH_MIDUNK) && smp < lo) begin
                            phase_next = PH_LOW;
                            if (pol_reg) first_next = cnt_inc;
                            else         finish = 1'b1;
                        end

                        // breath end: judge the breath just closed
                        if (finish) begin
                            cnt_next    = '0;
                            first_next  = '0;
                            bvalid_next = 1'b1;
                            if (bvalid_reg) begin
                                abn_next = abn_new;
                                if (flip) begin
                                    abn_next = 4'd0;
                                    pol_next = !pol_reg;
                                end else if (cnt_inc != '0) begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (in_range) begin
                        rate_next    = div_quot[15:0];
                        rate_ok_next = 1'b1;
                        done_next    = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, pol_reg, phase_reg, done_reg, rate_ok_reg,
                                     rate_ok_reg ? rate_reg : 16'h0000};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_UNKNOWN;
            cnt_reg      <= '0;
            first_reg    <= '0;
            abn_reg      <= 4'd0;
            pol_reg      <= 1'b1;
            bvalid_reg   <= 1'b0;
            rate_reg     <= '0;
            rate_ok_reg  <= 1'b0;
            done_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            abn_reg      <= abn_next;
            pol_reg      <= pol_next;
            bvalid_reg   <= bvalid_next;
            rate_reg     <= rate_next;
            rate_ok_reg  <= rate_ok_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- checks ----
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_first_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        first_reg <= cnt_reg)
        else $error("first part longer than the running breath count");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("sample beat taken without leaving idle");

    a_done_has_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[17] |-> m_tdata_reg[16])
        else $error("breath_done without a valid rate");

endmodule

@@ rtl/bcrd_cfg_regs.sv @@
// ============================================================================
// bcrd_cfg_regs - APB configuration register file
// Six settings registers, write decode and read back.
// ============================================================================
module bcrd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bcrd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bcrd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bcrd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output bcrd_pkg::cfg_t                   cfg
);

    bcrd_pkg::cfg_t cfg_reg;
    bcrd_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[bcrd_pkg::CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                bcrd_pkg::REG_MIN_AMP:   cfg_next.min_amplitude      = pwdata[14:0];
                bcrd_pkg::REG_MAX_AMP:   cfg_next.max_amplitude      = pwdata[14:0];
                bcrd_pkg::REG_FS:        cfg_next.sample_rate        = pwdata[15:0];
                bcrd_pkg::REG_LOW_RATE:  cfg_next.lowest_rate        = pwdata[15:0];
                bcrd_pkg::REG_HIGH_RATE: cfg_next.highest_rate       = pwdata[15:0];
                bcrd_pkg::REG_RUN_LIMIT: cfg_next.abnormal_run_limit = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bcrd_pkg::REG_MIN_AMP:   prdata = {17'b0, cfg_reg.min_amplitude};
            bcrd_pkg::REG_MAX_AMP:   prdata = {17'b0, cfg_reg.max_amplitude};
            bcrd_pkg::REG_FS:        prdata = {16'b0, cfg_reg.sample_rate};
            bcrd_pkg::REG_LOW_RATE:  prdata = {16'b0, cfg_reg.lowest_rate};
            bcrd_pkg::REG_HIGH_RATE: prdata = {16'b0, cfg_reg.highest_rate};
            bcrd_pkg::REG_RUN_LIMIT: prdata = {28'b0, cfg_reg.abnormal_run_limit};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_amplitude      <= bcrd_pkg::RST_MIN_AMP;
            cfg_reg.max_amplitude      <= bcrd_pkg::RST_MAX_AMP;
            cfg_reg.sample_rate        <= bcrd_pkg::RST_FS;
            cfg_reg.lowest_rate        <= bcrd_pkg::RST_LOW_RATE;
            cfg_reg.highest_rate       <= bcrd_pkg::RST_HIGH_RATE;
            cfg_reg.abnormal_run_limit <= bcrd_pkg::RST_RUN_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/bcrd_div.sv @@
// ============================================================================
// bcrd_div - bit-serial restoring divider
// One quotient bit per cycle, MSB first; DVD_W quotient bits per divide.
// ============================================================================
module bcrd_div #(
    parameter int COUNT_BITS = bcrd_pkg::DEF_COUNT_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bcrd_pkg::DVD_W-1:0]  dividend,
    input  logic [COUNT_BITS-1:0]       divisor,
    output logic                        done,
    output logic [bcrd_pkg::DVD_W-1:0]  quotient
);

    localparam int DW     = bcrd_pkg::DVD_W;
    localparam int ITER_W = $clog2(DW);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DW - 1);

    // dividend shifts out at the top while quotient bits shift in at the bottom
    logic [DW-1:0]         dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    assign shifted = {rem_reg, dvd_reg[DW-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        iter_next = iter_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            iter_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            dvd_next  = {dvd_reg[DW-2:0], fits};
            rem_next  = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ tb/bcrd_status_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// bcrd_status_checker - status beat predictor and scoreboard
// Snoops APB writes and sample beats, predicts the status beat of every
// sample and compares each output beat with the oldest prediction.
// ============================================================================
module bcrd_status_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // [15:0] signal, [16] signal_valid, [32:17] upper_level,
    // [33] upper_valid, [49:34] lower_level, [50] lower_valid, [55:51] zero
    input  logic [55:0]                         s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] rate, [16] rate_valid, [17] breath_done, [20:18] phase,
    // [21] inspiration_above, [23:22] zero
    input  logic [23:0]                         m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [bcrd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bcrd_pkg::CFG_DATA_W-1:0]     pwdata,
    output int                                  fail_count,
    output int                                  beats_checked,
    output int                                  rates_stored
);

    typedef enum logic [2:0] {
        PH_UNKNOWN = 3'd0,
        PH_LOW     = 3'd1,
        PH_HIGH    = 3'd2,
        PH_RISING  = 3'd3,
        PH_FALLING = 3'd4,
        PH_MIDUNK  = 3'd5
    } breath_phase_e;

    typedef struct packed {
        logic [15:0] rate;
        logic        rate_valid;
        logic        breath_done;
        logic [2:0]  phase;
        logic        insp_above;
    } status_t;

    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    bcrd_pkg::cfg_t cfg;
    breath_phase_e  phase_q;
    logic [15:0]    count_q;
    logic [15:0]    first_len_q;
    logic [3:0]     abn_run_q;
    logic           insp_above_q;
    logic           breath_open_q;
    logic [15:0]    rate_q;
    logic           rate_ok_q;

    status_t expected_status[$];
    int      n_fail    = 0;
    int      n_checked = 0;
    int      n_stored  = 0;

    function automatic void drop_rate();
        rate_q        = '0;
        rate_ok_q     = 1'b0;
        breath_open_q = 1'b0;
    endfunction

    // Breath end: abnormal tracking, polarity flip or rate store.
    function automatic logic close_breath();
        logic    stored;
        longint  quot;
        stored = 1'b0;
        if (breath_open_q) begin
            if (int'(first_len_q) > int'(count_q) - int'(first_len_q)) begin
                if (abn_run_q != 4'd15)
                    abn_run_q = abn_run_q + 4'd1;
            end else begin
                abn_run_q = '0;
            end
            if (abn_run_q >= cfg.abnormal_run_limit) begin
                abn_run_q    = '0;
                insp_above_q = !insp_above_q;
            end else if (count_q != '0) begin
                quot = (60 * longint'(cfg.sample_rate)) / longint'(count_q);
                if (quot >= longint'(cfg.lowest_rate) && quot <= longint'(cfg.highest_rate))
                begin
                    rate_q    = quot[15:0];
                    rate_ok_q = 1'b1;
                    stored    = 1'b1;
                end
            end
        end
        count_q       = '0;
        first_len_q   = '0;
        breath_open_q = 1'b1;
        return stored;
    endfunction

    function automatic status_t predict_status(input logic [55:0] beat);
        logic signed [15:0] sig, upl, lol;
        int                 spread;
        logic               done;
        status_t            res;
        sig  = beat[15:0];
        upl  = beat[32:17];
        lol  = beat[49:34];
        done = 1'b0;
        if (count_q != COUNT_SAT)
            count_q = count_q + 16'd1;
        if (!(beat[16] && beat[33] && beat[50])) begin
            drop_rate();
        end else begin
            if (phase_q == PH_UNKNOWN) begin
                if (sig < lol)      phase_q = PH_LOW;
                else if (sig > upl) phase_q = PH_HIGH;
                else                phase_q = PH_MIDUNK;
            end
            spread = int'(upl) - int'(lol);
            if (spread < 2 * int'(cfg.min_amplitude) || spread > 2 * int'(cfg.max_amplitude))
            begin
                phase_q = PH_UNKNOWN;
                drop_rate();
            end else if (phase_q == PH_LOW && sig > lol) begin
                phase_q = PH_RISING;
            end else if (phase_q == PH_HIGH && sig < upl) begin
                phase_q = PH_FALLING;
            end else if ((phase_q == PH_RISING || phase_q == PH_MIDUNK) && sig > upl) begin
                phase_q = PH_HIGH;
                if (insp_above_q) done = close_breath();
                else              first_len_q = count_q;
            end else if ((phase_q == PH_FALLING || phase_q == PH_MIDUNK) && sig < lol) begin
                phase_q = PH_LOW;
                if (insp_above_q) first_len_q = count_q;
                else              done = close_breath();
            end
        end
        res.rate        = rate_ok_q ? rate_q : 16'd0;
        res.rate_valid  = rate_ok_q;
        res.breath_done = done;
        res.phase       = phase_q;
        res.insp_above  = insp_above_q;
        return res;
    endfunction

    always @(posedge aclk) begin
        status_t got, want;
        if (!aresetn) begin
            cfg.min_amplitude      = bcrd_pkg::RST_MIN_AMP;
            cfg.max_amplitude      = bcrd_pkg::RST_MAX_AMP;
            cfg.sample_rate        = bcrd_pkg::RST_FS;
            cfg.lowest_rate        = bcrd_pkg::RST_LOW_RATE;
            cfg.highest_rate       = bcrd_pkg::RST_HIGH_RATE;
            cfg.abnormal_run_limit = bcrd_pkg::RST_RUN_LIMIT;
            phase_q       = PH_UNKNOWN;
            count_q       = '0;
            first_len_q   = '0;
            abn_run_q     = '0;
            insp_above_q  = 1'b1;
            breath_open_q = 1'b0;
            rate_q        = '0;
            rate_ok_q     = 1'b0;
            expected_status.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[bcrd_pkg::CFG_ADDR_W-1:2])
                    bcrd_pkg::REG_MIN_AMP:   cfg.min_amplitude      = pwdata[14:0];
                    bcrd_pkg::REG_MAX_AMP:   cfg.max_amplitude      = pwdata[14:0];
                    bcrd_pkg::REG_FS:        cfg.sample_rate        = pwdata[15:0];
                    bcrd_pkg::REG_LOW_RATE:  cfg.lowest_rate        = pwdata[15:0];
                    bcrd_pkg::REG_HIGH_RATE: cfg.highest_rate       = pwdata[15:0];
                    bcrd_pkg::REG_RUN_LIMIT: cfg.abnormal_run_limit = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = predict_status(s_tdata);
                if (want.breath_done)
                    n_stored++;
                expected_status.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.rate        = m_tdata[15:0];
                got.rate_valid  = m_tdata[16];
                got.breath_done = m_tdata[17];
                got.phase       = m_tdata[20:18];
                got.insp_above  = m_tdata[21];
                n_checked++;
                if (expected_status.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("ERROR @%0t: status beat %0d with no sample pending: %h",
                                 $time, n_checked, m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    if (got.rate != want.rate || got.rate_valid != want.rate_valid ||
                        got.breath_done != want.breath_done || got.phase != want.phase ||
                        got.insp_above != want.insp_above) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("ERROR @%0t: beat %0d rate %h/%h rate_valid %b/%b",
                                     $time, n_checked, want.rate, got.rate,
                                     want.rate_valid, got.rate_valid);
                            $display("    done %b/%b phase %0d/%0d above %b/%b (exp/got)",
                                     want.breath_done, got.breath_done,
                                     want.phase, got.phase,
                                     want.insp_above, got.insp_above);
                        end
                    end
                end
            end
        end
        fail_count    <= n_fail;
        beats_checked <= n_checked;
        rates_stored  <= n_stored;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top - breath cycle rate detector testbench
// Drives sample beats and APB settings through several phases with random
// source gaps and sink stalls; the checker predicts and scores every beat.
// ============================================================================
module tb_top;

    // no beat accepted for this long means the block hung; the slowest
    // sample is a breath end that runs the divider, plus a random sink stall
    localparam int WATCHDOG_LIMIT = 5000;
    // quiet time after the last status beat before touching settings
    localparam int SETTLE_CYCLES  = 40;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    // [15:0] signal, [16] signal_valid, [32:17] upper_level,
    // [33] upper_valid, [49:34] lower_level, [50] lower_valid, [55:51] zero
    logic [55:0]                       s_tdata;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // [15:0] rate, [16] rate_valid, [17] breath_done, [20:18] phase,
    // [21] inspiration_above, [23:22] zero
    logic [23:0]                       m_tdata;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [bcrd_pkg::CFG_ADDR_W-1:0]   paddr;
    logic [bcrd_pkg::CFG_DATA_W-1:0]   pwdata;
    logic [bcrd_pkg::CFG_DATA_W-1:0]   prdata;
    logic                              pready;

    int   fail_count;
    int   beats_checked;
    int   rates_stored;

    int   samples_sent = 0;
    int   phases_run   = 0;
    int   src_pct      = 0;   // chance in 100 of a source gap cycle
    int   snk_pct      = 0;   // chance in 100 of a sink stall cycle
    int   half_len     = 30;  // longest ramp half of a generated breath
    int   quiet_cycles = 0;
    bcrd_pkg::cfg_t cur_cfg;

    breath_cycle_rate_detector DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bcrd_status_checker status_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .beats_checked (beats_checked),
        .rates_stored  (rates_stored)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sink side: random stall per cycle at the current rate
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= snk_pct);

    // watchdog: any accepted beat on either side restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no beat accepted for %0d cycles, %0d sent, %0d checked",
                     WATCHDOG_LIMIT, samples_sent, beats_checked);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [55:0] pack_sample(input int sig, input bit sv, input int up,
                                                input bit uv, input int lo, input bit lv);
        return {5'b0, lv, lo[15:0], uv, up[15:0], sv, sig[15:0]};
    endfunction

    function automatic bcrd_pkg::cfg_t make_cfg(input int mn, input int mx, input int fs,
                                                input int lo_rate, input int hi_rate,
                                                input int lim);
        bcrd_pkg::cfg_t c;
        c.min_amplitude      = mn[14:0];
        c.max_amplitude      = mx[14:0];
        c.sample_rate        = fs[15:0];
        c.lowest_rate        = lo_rate[15:0];
        c.highest_rate       = hi_rate[15:0];
        c.abnormal_run_limit = lim[3:0];
        return c;
    endfunction

    function automatic void set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin src_pct = 0;  snk_pct = 0;  end
            IDLE_SRC:  begin src_pct = 58; snk_pct = 0;  end
            IDLE_SNK:  begin src_pct = 0;  snk_pct = 58; end
            IDLE_BOTH: begin src_pct = 31; snk_pct = 31; end
            default:   begin src_pct = 0;  snk_pct = 0;  end
        endcase
    endfunction

    // One sample beat. s_tvalid only drops when a gap is taken, so a
    // back-to-back beat never sees a low and a high in the same step.
    task automatic push_sample(input logic [55:0] beat);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Hold the source until every status beat is back, then let the
    // block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (beats_checked != samples_sent)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup, access until pready, then idle with psel low.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(input bcrd_pkg::cfg_t c);
        cur_cfg = c;
        reg_write(bcrd_pkg::REG_MIN_AMP,   32'(c.min_amplitude));
        reg_write(bcrd_pkg::REG_MAX_AMP,   32'(c.max_amplitude));
        reg_write(bcrd_pkg::REG_FS,        32'(c.sample_rate));
        reg_write(bcrd_pkg::REG_LOW_RATE,  32'(c.lowest_rate));
        reg_write(bcrd_pkg::REG_HIGH_RATE, 32'(c.highest_rate));
        reg_write(bcrd_pkg::REG_RUN_LIMIT, 32'(c.abnormal_run_limit));
    endtask

    // A train of triangle breaths around fixed thresholds. The half spread
    // sits in the allowed window unless it is empty (edges included now
    // and then); the swing overshoots both thresholds by a random margin.
    task automatic breath_train();
        int hmin, hmax, h, m, r, c, amp, n_breaths, a, b, v;
        hmin = int'(cur_cfg.min_amplitude);
        hmax = int'(cur_cfg.max_amplitude);
        if (hmax > 30000)
            hmax = 30000;
        if (hmin > hmax)
            h = $urandom_range(30000, 0);
        else begin
            case ($urandom_range(7))
                0:       h = hmin;
                1:       h = hmax;
                default: h = $urandom_range(hmax, hmin);
            endcase
        end
        m   = $urandom_range(2000, 1);
        r   = 32767 - h - m;
        c   = int'($urandom_range(2 * r, 0)) - r;
        amp = h + m;
        n_breaths = $urandom_range(5, 1);
        repeat (n_breaths) begin
            a = $urandom_range(half_len, 1);
            b = $urandom_range(half_len, 1);
            for (int i = 0; i < a; i++) begin
                v = c - amp + (2 * amp * (i + 1)) / a;
                push_sample(pack_sample(v, 1'b1, c + h, 1'b1, c - h, 1'b1));
            end
            for (int i = 0; i < b; i++) begin
                v = c + amp - (2 * amp * (i + 1)) / b;
                push_sample(pack_sample(v, 1'b1, c + h, 1'b1, c - h, 1'b1));
            end
        end
    endtask

    // Spread window edge cases: random thresholds, or a spread just under
    // twice the minimum or just over twice the maximum.
    task automatic spread_fault();
        int sp, lo;
        case ($urandom_range(2))
            1:       sp = 2 * int'(cur_cfg.min_amplitude) - 1;
            2:       sp = 2 * int'(cur_cfg.max_amplitude) + 1;
            default: sp = -1;
        endcase
        if (sp < 0 || sp > 65535)
            push_sample(pack_sample($urandom, 1'b1, $urandom, 1'b1, $urandom, 1'b1));
        else begin
            lo = -32768 + int'($urandom_range(65535 - sp, 0));
            push_sample(pack_sample($urandom, 1'b1, lo + sp, 1'b1, lo, 1'b1));
        end
    endtask

    task automatic random_samples(input int count);
        int target, pick, flags;
        target = samples_sent + count;
        while (samples_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                breath_train();
            end else if (pick < 88) begin
                repeat ($urandom_range(4, 1))
                    push_sample(pack_sample($urandom, $urandom_range(7) != 0,
                                            $urandom, $urandom_range(7) != 0,
                                            $urandom, $urandom_range(7) != 0));
            end else if (pick < 94) begin
                // at least one flag marks a NaN
                flags = $urandom_range(6, 0);
                push_sample(pack_sample($urandom_range(2000) - 1000, flags[0],
                                        1000, flags[1], -1000, flags[2]));
            end else begin
                spread_fault();
            end
            // source holds off until the sink has caught up
            if ($urandom_range(24) == 0)
                drain_results();
        end
    endtask

    task automatic run_phase(input bcrd_pkg::cfg_t c, input idle_mode_e mode,
                             input int n_items, input int ramp_len);
        drain_results();
        apply_cfg(c);
        set_idle(mode);
        half_len = ramp_len;
        phases_run++;
        random_samples(n_items);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_cfg  = make_cfg(int'(bcrd_pkg::RST_MIN_AMP), int'(bcrd_pkg::RST_MAX_AMP),
                            int'(bcrd_pkg::RST_FS), int'(bcrd_pkg::RST_LOW_RATE),
                            int'(bcrd_pkg::RST_HIGH_RATE), int'(bcrd_pkg::RST_RUN_LIMIT));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed, reset settings: spread window is [820, 32768] ----
        set_idle(IDLE_NONE);
        phases_run++;
        push_sample(pack_sample(0, 1'b0, 1000, 1'b1, -1000, 1'b1));         // signal NaN
        push_sample(pack_sample(0, 1'b1, 1000, 1'b0, -1000, 1'b1));         // upper NaN
        push_sample(pack_sample(0, 1'b1, 1000, 1'b1, -1000, 1'b0));         // lower NaN
        push_sample(pack_sample(0, 1'b1, 1000, 1'b1, -1000, 1'b1));         // unknown -> mid
        push_sample(pack_sample(-32768, 1'b1, 16384, 1'b1, -16384, 1'b1));  // max spread, low
        push_sample(pack_sample(32767, 1'b1, 16384, 1'b1, -16384, 1'b1));   // low -> rising
        push_sample(pack_sample(16384, 1'b1, 16384, 1'b1, -16384, 1'b1));   // on upper, hold
        push_sample(pack_sample(16385, 1'b1, 16384, 1'b1, -16384, 1'b1));   // -> high, end
        push_sample(pack_sample(16384, 1'b1, 16384, 1'b1, -16384, 1'b1));   // on upper, hold
        push_sample(pack_sample(-16384, 1'b1, 16384, 1'b1, -16384, 1'b1));  // -> falling
        push_sample(pack_sample(-16385, 1'b1, 16384, 1'b1, -16384, 1'b1));  // -> low, mark
        push_sample(pack_sample(0, 1'b1, 16384, 1'b1, -16384, 1'b1));       // low -> rising
        push_sample(pack_sample(20000, 1'b1, 16384, 1'b1, -16384, 1'b1));   // end, too fast
        push_sample(pack_sample(0, 1'b1, 410, 1'b1, -410, 1'b1));           // spread at min
        push_sample(pack_sample(0, 1'b1, 410, 1'b1, -409, 1'b1));           // under min
        push_sample(pack_sample(0, 1'b1, 16385, 1'b1, -16384, 1'b1));       // over max
        push_sample(pack_sample(0, 1'b1, 32767, 1'b1, -32768, 1'b1));       // widest spread
        push_sample(pack_sample(0, 1'b1, -100, 1'b1, 100, 1'b1));           // negative spread
        push_sample(pack_sample(32767, 1'b1, 1000, 1'b1, -1000, 1'b1));     // unknown -> high
        push_sample(pack_sample(-32768, 1'b0, -32768, 1'b0, 32767, 1'b0));  // all NaN
        push_sample(pack_sample(-32768, 1'b1, 1000, 1'b1, -1000, 1'b1));    // high -> falling
        drain_results();

        // ---- random phases ----
        half_len = 30;
        random_samples(80);

        // wide-open settings
        run_phase(make_cfg(0, 32767, 65535, 0, 65535, 15), IDLE_SRC, 60, 30);

        run_phase(make_cfg(1000, 8000, 512, 1000, 8000, 1), IDLE_SNK, 80, 15);
        // limit of zero: every judged breath flips polarity
        run_phase(make_cfg(200, 20000, 100, 0, 65535, 0), IDLE_BOTH, 80, 12);
        // empty window: every valid sample resets the phase
        run_phase(make_cfg(32767, 0, 1, 65535, 0, 2), IDLE_NONE, 30, 10);
        // zero sample rate and a single-point spread window
        run_phase(make_cfg(300, 300, 0, 0, 100, 2), IDLE_SRC, 50, 10);
        run_phase(make_cfg($urandom_range(4000), $urandom_range(30000, 4000),
                           $urandom_range(1024, 64), $urandom_range(2000),
                           $urandom_range(65535, 4000), $urandom_range(15, 1)),
                  IDLE_BOTH, 80, 20);
        // lowest sample rate: only long breaths give a zero-rate quotient
        run_phase(make_cfg(0, 32767, 1, 0, 0, 15), IDLE_NONE, 60, 40);

        drain_results();

        $display("Summary: %0d samples in %0d setting phases, %0d status beats scored",
                 samples_sent, phases_run, beats_checked);
        $display("Summary: %0d rates stored; NaN flags, spread edges, polarity flips hit",
                 rates_stored);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
